// File: sv/etwm_pkg.sv
// Shared types and constants of the telemetry window monitor.
`timescale 1ns / 1ps
`default_nettype none

package etwm_pkg;

    // Item kinds carried in tuser.
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_TICKS   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALERT_HOLDOFF  = 1'd1;
    localparam int CFG_DATA_W  = 16;

    // Message types decoded from the extended identifier.
    localparam logic [15:0] TYPE_CURRENT = 16'd20051;
    localparam logic [15:0] TYPE_TEMP    = 16'd20052;

    // Field widths.
    localparam int IDENT_W   = 29;
    localparam int PAYLOAD_W = 48;
    localparam int TEMP_W    = 8;
    localparam int SUM_W     = 21;
    localparam int COUNT_W   = 6;
    localparam int TICK_W    = 16;

    localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 40;

    // One accepted input item.
    typedef struct packed {
        logic                 kind;
        logic [IDENT_W-1:0]   can_ident;
        logic [PAYLOAD_W-1:0] payload;
    } t_item;

    // One window report.
    typedef struct packed {
        logic                 link_lost_alert;
        logic [COUNT_W-1:0]   node_count;
        logic [SUM_W-1:0]     current_total;
        logic                 temperature_seen;
        logic [TEMP_W-1:0]    peak_temperature;
    } t_report;

endpackage

`default_nettype wire

// File: sv/esc_telemetry_window_monitor.sv
// Top level of the motor-controller telemetry window monitor.
`timescale 1ns / 1ps
`default_nettype none

// The monitor takes telemetry frames (tuser low) and time ticks (tuser high),
// one request per clock. Bus-current reports add the first reading of each node
// in slots 0 to NODE_SLOTS-1 to the window sum; temperature reports track the
// peak. The tick that carries the window count past window_ticks emits one
// report and clears the window. Each request is held in the input register
// and updates the window state as it leaves it; its report is then written to
// the result register and offered on the master side. A new request is taken
// every cycle while the result register is empty or being drained; a report
// not taken stalls the input register, which then holds one request.
// Configuration writes are taken at any time and should be made while idle.
module esc_telemetry_window_monitor import etwm_pkg::*; #(
    parameter int NODE_SLOTS = 32
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // Configuration write port.
    input  wire                    i_cfg_we,
    input  wire [CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire [CFG_DATA_W-1:0]   i_cfg_data,
    // Input stream.
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata: can_ident [28:0], payload [76:29], zero [79:77]
    input  wire [IN_TDATA_W-1:0]   s_axis_tdata,
    // tuser: kind [0]
    input  wire                    s_axis_tuser,
    // Report stream.
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    // tdata: peak_temperature [7:0], temperature_seen [8], current_total [29:9],
    //        node_count [35:30], link_lost_alert [36], zero [39:37]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [TICK_W-1:0] r_window_ticks;
    logic [TICK_W-1:0] r_holdoff_ticks;

    logic              r_in_valid, n_in_valid;
    t_item             r_in, n_in;
    logic              r_out_valid, n_out_valid;
    t_report           r_out, n_out;

    logic              w_out_free;
    logic              w_fire;
    logic              w_accept;
    logic              w_report_valid;
    t_report           w_report;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_ticks  <= TICK_W'(1200);
            r_holdoff_ticks <= TICK_W'(6000);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WINDOW_TICKS:  r_window_ticks  <= i_cfg_data;
                CFG_ALERT_HOLDOFF: r_holdoff_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake: the held request moves on when the result slot is free.
    always_comb begin
        w_out_free    = !r_out_valid || m_axis_tready;
        w_fire        = r_in_valid && w_out_free;
        s_axis_tready = !r_in_valid || w_out_free;
        w_accept      = s_axis_tvalid && s_axis_tready;
    end

    // Input register.
    always_comb begin
        n_in_valid = r_in_valid;
        n_in       = r_in;
        if (w_accept) begin
            n_in_valid     = 1'b1;
            n_in.kind      = s_axis_tuser;
            n_in.can_ident = s_axis_tdata[IDENT_W-1:0];
            n_in.payload   = s_axis_tdata[IDENT_W+PAYLOAD_W-1:IDENT_W];
        end else if (w_fire) begin
            n_in_valid = 1'b0;
        end
    end

    etwm_window_core #(
        .NODE_SLOTS (NODE_SLOTS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (w_fire),
        .i_item          (r_in),
        .i_window_ticks  (r_window_ticks),
        .i_holdoff_ticks (r_holdoff_ticks),
        .o_report_valid  (w_report_valid),
        .o_report        (w_report)
    );

    // Result register.
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (w_fire && w_report_valid) begin
            n_out_valid = 1'b1;
            n_out       = w_report;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in  <= n_in;
        r_out <= n_out;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out);

endmodule

`default_nettype wire

// File: sv/etwm_window_core.sv
// Window state of the telemetry monitor: accumulators, node masks and counters.
`timescale 1ns / 1ps
`default_nettype none

module etwm_window_core import etwm_pkg::*; #(
    parameter int NODE_SLOTS = 32
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_fire,
    input  t_item                  i_item,
    input  wire [TICK_W-1:0]       i_window_ticks,
    input  wire [TICK_W-1:0]       i_holdoff_ticks,
    output logic                   o_report_valid,
    output t_report                o_report
);

    logic [NODE_SLOTS-1:0] r_seen, n_seen;
    logic [NODE_SLOTS-1:0] r_ever, n_ever;
    logic [TEMP_W-1:0]     r_peak, n_peak;
    logic                  r_peak_valid, n_peak_valid;
    logic [SUM_W-1:0]      r_sum, n_sum;
    logic [COUNT_W-1:0]    r_count, n_count;
    logic [TICK_W-1:0]     r_window, n_window;
    logic [TICK_W-1:0]     r_holdoff, n_holdoff;

    logic [6:0]            w_node;
    logic [15:0]           w_type;
    logic [NODE_SLOTS-1:0] w_node_bit;
    logic                  w_new_node;
    logic [SUM_W:0]        w_sum_ext;
    logic [SUM_W-1:0]      w_sum_sat;
    logic [TEMP_W-1:0]     w_temp;
    logic [TICK_W-1:0]     w_holdoff_inc;
    logic                  w_window_end;
    logic                  w_alert;

    // Identifier decode and per-frame updates.
    always_comb begin
        w_node     = i_item.can_ident[6:0];
        w_type     = i_item.can_ident[23:8];
        w_node_bit = NODE_SLOTS'(1'b1) << w_node;
        w_new_node = (w_type == TYPE_CURRENT) && (32'(w_node) < NODE_SLOTS) &&
                     ((r_seen & w_node_bit) == '0);
        w_sum_ext  = {1'b0, r_sum} + (SUM_W + 1)'(i_item.payload[31:16]);
        w_sum_sat  = w_sum_ext[SUM_W] ? SUM_MAX : w_sum_ext[SUM_W-1:0];
        w_temp     = i_item.payload[7:0];
    end

    // Tick handling: saturating holdoff counter and window end detection.
    always_comb begin
        w_holdoff_inc = (r_holdoff == '1) ? r_holdoff : r_holdoff + TICK_W'(1);
        w_window_end  = (r_window >= i_window_ticks);
        w_alert       = ((r_ever & ~r_seen) != '0) && (w_holdoff_inc > i_holdoff_ticks);
    end

    // Report contents are the window state as it stands at the closing tick.
    always_comb begin
        o_report_valid            = i_fire && (i_item.kind == KIND_TICK) && w_window_end;
        o_report.peak_temperature = r_peak_valid ? r_peak : '0;
        o_report.temperature_seen = r_peak_valid;
        o_report.current_total    = r_sum;
        o_report.node_count       = r_count;
        o_report.link_lost_alert  = w_alert;
    end

    // Next state.
    always_comb begin
        n_seen       = r_seen;
        n_ever       = r_ever;
        n_peak       = r_peak;
        n_peak_valid = r_peak_valid;
        n_sum        = r_sum;
        n_count      = r_count;
        n_window     = r_window;
        n_holdoff    = r_holdoff;
        if (i_fire) begin
            if (i_item.kind == KIND_FRAME) begin
                if (w_new_node) begin
                    n_seen  = r_seen | w_node_bit;
                    n_sum   = w_sum_sat;
                    n_count = (r_count == COUNT_MAX) ? r_count : r_count + COUNT_W'(1);
                end
                if ((w_type == TYPE_TEMP) && (!r_peak_valid || (w_temp > r_peak))) begin
                    n_peak       = w_temp;
                    n_peak_valid = 1'b1;
                end
            end else begin
                n_holdoff = w_holdoff_inc;
                if (!w_window_end) begin
                    n_window = r_window + TICK_W'(1);
                end else begin
                    n_window     = '0;
                    if (w_alert) begin
                        n_holdoff = '0;
                    end
                    n_ever       = r_ever | r_seen;
                    n_seen       = '0;
                    n_sum        = '0;
                    n_count      = '0;
                    n_peak       = '0;
                    n_peak_valid = 1'b0;
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen       <= '0;
            r_ever       <= '0;
            r_peak       <= '0;
            r_peak_valid <= 1'b0;
            r_sum        <= '0;
            r_count      <= '0;
            r_window     <= '0;
            r_holdoff    <= '0;
        end else begin
            r_seen       <= n_seen;
            r_ever       <= n_ever;
            r_peak       <= n_peak;
            r_peak_valid <= n_peak_valid;
            r_sum        <= n_sum;
            r_count      <= n_count;
            r_window     <= n_window;
            r_holdoff    <= n_holdoff;
        end
    end

endmodule

`default_nettype wire

// File: sv/etwm_checker.sv
// Port-level checks of the telemetry window monitor and their binding.
`timescale 1ns / 1ps
`default_nettype none

module etwm_checker import etwm_pkg::*; #(
    parameter int NODE_SLOTS = 32
) (
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   i_m_tvalid,
    input wire                   i_m_tready,
    input wire [OUT_TDATA_W-1:0] i_m_tdata
);

    logic [TEMP_W-1:0]  w_peak;
    logic               w_temp_seen;
    logic [SUM_W-1:0]   w_sum;
    logic [COUNT_W-1:0] w_count;

    always_comb begin
        w_peak      = i_m_tdata[7:0];
        w_temp_seen = i_m_tdata[8];
        w_sum       = i_m_tdata[29:9];
        w_count     = i_m_tdata[35:30];
    end

    // A stalled report stays offered.
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid)
        else $error("report withdrawn while stalled");

    // A stalled report keeps its contents.
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> $stable(i_m_tdata))
        else $error("report changed while stalled");

    // Without a temperature report the peak reads as zero.
    a_peak_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !w_temp_seen |-> w_peak == '0)
        else $error("peak temperature without a temperature report");

    // No counted node means no current in the sum.
    a_sum_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && w_count == '0 |-> w_sum == '0)
        else $error("current sum without any counted node");

    // The node count never exceeds the number of slots.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> 32'(w_count) <= NODE_SLOTS)
        else $error("node count above slot number");

endmodule

bind esc_telemetry_window_monitor etwm_checker #(
    .NODE_SLOTS (NODE_SLOTS)
) u_etwm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);

`default_nettype wire
